/* rtl/cda_pkg.sv */
package cda_pkg;

   localparam int COORD_WIDTH     = 20;
   localparam int ANGLE_FRAC_BITS = 7;
   localparam int AXIS_WIDTH      = 20;
   localparam int ACC_FRAC        = 20;
   localparam int CORDIC_STEPS    = 24;
   localparam int DIFF_WIDTH      = COORD_WIDTH + 1;
   localparam int PROD_WIDTH      = 48;
   localparam int DOT_WIDTH       = 48;
   localparam int CVAL_WIDTH      = 34;
   localparam int Z_WIDTH         = 32;
   localparam int OUT_SHIFT       = ACC_FRAC - ANGLE_FRAC_BITS;

   localparam logic signed [Z_WIDTH-1:0] DEG90_ACC  = 32'sd94371840;
   localparam logic signed [Z_WIDTH-1:0] DEG180_ACC = 32'sd188743680;
   localparam logic [19:0] DIST_MAX = 20'hFFFFF;
   localparam logic signed [15:0] ANGLE_180 = 16'(180 << ANGLE_FRAC_BITS);
   localparam logic signed [15:0] ANGLE_90  = 16'(90 << ANGLE_FRAC_BITS);

   localparam logic [1:0] SYM_TWO  = 2'd1;
   localparam logic [1:0] SYM_FOUR = 2'd2;

   function automatic logic signed [Z_WIDTH-1:0] atan_step(input logic [4:0] i);
      logic signed [Z_WIDTH-1:0] r;
      begin
         case (i)
            5'd0: r = 47185920;   5'd1: r = 27855475;  5'd2: r = 14718068;
            5'd3: r = 7471121;    5'd4: r = 3750058;   5'd5: r = 1876857;
            5'd6: r = 938658;     5'd7: r = 469357;    5'd8: r = 234682;
            5'd9: r = 117342;     5'd10: r = 58671;    5'd11: r = 29335;
            5'd12: r = 14668;     5'd13: r = 7334;     5'd14: r = 3667;
            5'd15: r = 1833;      5'd16: r = 917;      5'd17: r = 458;
            5'd18: r = 229;       5'd19: r = 115;      5'd20: r = 57;
            5'd21: r = 29;        5'd22: r = 14;       5'd23: r = 7;
            default: r = '0;
         endcase
         return r;
      end
   endfunction

   // Round 2^-20 degree to the output unit and clamp to +-180.
   function automatic logic signed [15:0] to_out_unit(input logic signed [Z_WIDTH-1:0] z);
      logic signed [Z_WIDTH:0] a;
      logic signed [Z_WIDTH:0] lim;
      begin
         lim = (Z_WIDTH+1)'(180 << ANGLE_FRAC_BITS);
         a = ((Z_WIDTH+1)'(z) + (Z_WIDTH+1)'(1 << (OUT_SHIFT - 1))) >>> OUT_SHIFT;
         if (a > lim) a = lim;
         if (a < -lim) a = -lim;
         return 16'(a);
      end
   endfunction

endpackage

/* rtl/cda_isqrt.sv */
// Pipelined restoring square root: one result bit per stage, floor root and remainder.
module cda_isqrt (
   input  logic        clock,
   input  logic [63:0] in_value,
   output logic [31:0] out_root,
   output logic [63:0] out_rem
);

   logic [63:0] rem_ff  [0:32];
   logic [31:0] root_ff [0:32];

   assign rem_ff[0]  = in_value;
   assign root_ff[0] = '0;

   genvar g;
   generate
      for (g = 0; g < 32; g++) begin : g_bit
         logic [63:0] rem_in;
         logic [31:0] root_in;
         logic [65:0] trial;
         logic [63:0] rem_reg_ff;
         logic [31:0] root_reg_ff;
         always_comb begin
            // Trial subtract of (4*root+1) << 2*(31-g), done on the top bits.
            trial = {2'b0, rem_ff[g]} - ({32'b0, root_ff[g], 2'b01} << (2 * (31 - g)));
            if (!trial[65]) begin
               rem_in  = trial[63:0];
               root_in = {root_ff[g][30:0], 1'b1};
            end else begin
               rem_in  = rem_ff[g];
               root_in = {root_ff[g][30:0], 1'b0};
            end
         end
         always_ff @(posedge clock) begin
            rem_reg_ff  <= rem_in;
            root_reg_ff <= root_in;
         end
         assign rem_ff[g+1]  = rem_reg_ff;
         assign root_ff[g+1] = root_reg_ff;
      end
   endgenerate

   assign out_root = root_ff[32];
   assign out_rem  = rem_ff[32];

endmodule

/* rtl/cda_cordic.sv */
// Pipelined CORDIC vectoring atan2 in 2^-20 degree. Normalisation, two stages,
// then one micro-rotation per stage.
module cda_cordic (
   input  logic                                 clock,
   input  logic signed [cda_pkg::DOT_WIDTH-1:0] in_y,
   input  logic signed [cda_pkg::DOT_WIDTH-1:0] in_x,
   output logic signed [cda_pkg::Z_WIDTH-1:0]   out_z
);

   localparam int W  = cda_pkg::DOT_WIDTH;
   localparam int CW = cda_pkg::CVAL_WIDTH;
   localparam int ZW = cda_pkg::Z_WIDTH;
   localparam int N  = cda_pkg::CORDIC_STEPS;
   localparam logic signed [W-1:0] NEG_TOP = W'(-64'sd1073741824);

   // Stage A: special cases and leading-bit position of max(|x|,|y|).
   logic [W-1:0] ax, ay, m;
   logic [5:0]   msb;
   logic         spec;
   logic signed [ZW-1:0] spec_z;
   always_comb begin
      ax = in_x[W-1] ? W'(-in_x) : W'(in_x);
      ay = in_y[W-1] ? W'(-in_y) : W'(in_y);
      m  = (ax > ay) ? ax : ay;
      msb = '0;
      for (int i = 0; i < W; i++)
         if (m[i]) msb = 6'(i);
      spec = 1'b0;
      spec_z = '0;
      if (in_x == '0) begin
         spec = 1'b1;
         spec_z = in_y[W-1] ? -cda_pkg::DEG90_ACC : cda_pkg::DEG90_ACC;
      end else if (in_y == '0) begin
         spec = 1'b1;
         spec_z = in_x[W-1] ? cda_pkg::DEG180_ACC : '0;
      end
   end

   logic signed [W-1:0]  xa_ff, ya_ff;
   logic [5:0]           msba_ff;
   logic                 speca_ff;
   logic signed [ZW-1:0] specza_ff;
   always_ff @(posedge clock) begin
      xa_ff <= in_x; ya_ff <= in_y; msba_ff <= msb;
      speca_ff <= spec; specza_ff <= spec_z;
   end

   // Stage B: shift so that the larger magnitude lies in [2^29, 2^30), then
   // fold into the right half plane. Right shifts by floor, as asr.
   logic signed [W-1:0] xn, yn, xs, ys;
   logic signed [CW-1:0] x0, y0;
   logic signed [ZW-1:0] z0;
   always_comb begin
      if (msba_ff > 6'd29) begin
         xn = xa_ff >>> (msba_ff - 6'd29);
         yn = ya_ff >>> (msba_ff - 6'd29);
      end else begin
         xn = xa_ff <<< (6'd29 - msba_ff);
         yn = ya_ff <<< (6'd29 - msba_ff);
      end
      // A negative operand can floor to exactly -2^30: take one more step.
      if (xn == NEG_TOP || yn == NEG_TOP) begin
         xs = xn >>> 1;
         ys = yn >>> 1;
      end else begin
         xs = xn;
         ys = yn;
      end
      z0 = '0;
      if (xs[W-1]) begin
         z0 = (ys > 0) ? cda_pkg::DEG180_ACC : -cda_pkg::DEG180_ACC;
         x0 = CW'(-xs);
         y0 = CW'(-ys);
      end else begin
         x0 = CW'(xs);
         y0 = CW'(ys);
      end
   end

   logic signed [CW-1:0] x_ff [0:N];
   logic signed [CW-1:0] y_ff [0:N];
   logic signed [ZW-1:0] z_ff [0:N];
   logic                 sp_ff [0:N];
   logic signed [ZW-1:0] spz_ff [0:N];
   always_ff @(posedge clock) begin
      x_ff[0] <= x0; y_ff[0] <= y0; z_ff[0] <= z0;
      sp_ff[0] <= speca_ff; spz_ff[0] <= specza_ff;
   end

   genvar g;
   generate
      for (g = 0; g < N; g++) begin : g_step
         logic signed [CW-1:0] xsh, ysh;
         assign xsh = x_ff[g] >>> g;
         assign ysh = y_ff[g] >>> g;
         always_ff @(posedge clock) begin
            if (y_ff[g] > 0) begin
               x_ff[g+1] <= x_ff[g] + ysh;
               y_ff[g+1] <= y_ff[g] - xsh;
               z_ff[g+1] <= z_ff[g] + cda_pkg::atan_step(5'(g));
            end else begin
               x_ff[g+1] <= x_ff[g] - ysh;
               y_ff[g+1] <= y_ff[g] + xsh;
               z_ff[g+1] <= z_ff[g] - cda_pkg::atan_step(5'(g));
            end
            sp_ff[g+1]  <= sp_ff[g];
            spz_ff[g+1] <= spz_ff[g];
         end
      end
   endgenerate

   assign out_z = sp_ff[N] ? spz_ff[N] : z_ff[N];

endmodule

/* rtl/contact_distance_and_angles.sv */
// Channel   | Direction | Ports                        | Handshake
// request   | in        | start, busy, req_*           | start & !busy
// response  | out       | rsp_valid, rsp_*             | one-cycle strobe, no hold-off
//
// A fully pipelined datapath: one transaction is taken every cycle, back to back.
// Its result is strobed on rsp_valid after six product and sum stages, the
// 32-stage square root, the 26-stage CORDIC, then the output register.
// busy is tied low: the receiver cannot stall, so nothing ever holds.
// reset (synchronous, active high) clears only the control pipeline; payload
// registers run free.
module contact_distance_and_angles (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [59:0] req_self_position,
   input  logic [59:0] req_partner_position,
   input  logic [59:0] req_axis_u,
   input  logic [59:0] req_axis_v,
   input  logic [59:0] req_axis_w,
   input  logic        req_has_u_axis,
   input  logic        req_has_v_axis,
   input  logic        req_u_symmetry,
   input  logic [1:0]  req_v_symmetry,
   output logic        rsp_valid,
   output logic [19:0] rsp_contact_distance,
   output logic [14:0] rsp_alpha_angle,
   output logic signed [15:0] rsp_beta_angle,
   output logic        rsp_alpha_valid,
   output logic        rsp_beta_valid
);

   localparam int CWD = cda_pkg::COORD_WIDTH;
   localparam int DW  = cda_pkg::DIFF_WIDTH;
   localparam int AW  = cda_pkg::AXIS_WIDTH;
   localparam int PW  = cda_pkg::PROD_WIDTH;
   // stage 1 diff, 2 products, 3 sums, 4 shift, 5 squares, 6 sum, 7-38 sqrt
   localparam int SQ_AT   = 6;
   localparam int LATENCY = SQ_AT + 32 + 26;

   assign busy = 1'b0;

   // Hold the flags along the whole pipe.
   typedef struct packed {
      logic       vld;
      logic       hu;
      logic       hv;
      logic       us;
      logic [1:0] vs;
   } ctl_type;

   ctl_type ctl_ff [0:LATENCY];
   ctl_type ctl_in;
   assign ctl_in = '{vld: start, hu: req_has_u_axis, hv: req_has_v_axis,
                     us: req_u_symmetry, vs: req_v_symmetry};
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= LATENCY; i++) ctl_ff[i] <= '0;
      end else begin
         ctl_ff[0] <= ctl_in;
         for (int i = 1; i <= LATENCY; i++) ctl_ff[i] <= ctl_ff[i-1];
      end
   end

   // Stage 1: contact vector and axes.
   logic signed [DW-1:0] d_ff [0:2];
   logic signed [AW-1:0] u_ff [0:2], v_ff [0:2], w_ff [0:2];
   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         d_ff[k] <= DW'($signed(req_partner_position[k*CWD +: CWD]))
                  - DW'($signed(req_self_position[k*CWD +: CWD]));
         u_ff[k] <= $signed(req_axis_u[k*AW +: AW]);
         v_ff[k] <= $signed(req_axis_v[k*AW +: AW]);
         w_ff[k] <= $signed(req_axis_w[k*AW +: AW]);
      end
   end

   // Stage 2: all products (21x21 for the squares, 21x20 for the rest).
   logic signed [PW-1:0] dd_ff [0:2], du_ff [0:2], dv_ff [0:2], dw_ff [0:2];
   logic signed [PW-1:0] cp_ff [0:5];
   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         dd_ff[k] <= PW'(d_ff[k]) * PW'(d_ff[k]);
         du_ff[k] <= PW'(d_ff[k]) * PW'(u_ff[k]);
         dv_ff[k] <= PW'(d_ff[k]) * PW'(v_ff[k]);
         dw_ff[k] <= PW'(d_ff[k]) * PW'(w_ff[k]);
      end
      cp_ff[0] <= PW'(d_ff[1]) * PW'(u_ff[2]);
      cp_ff[1] <= PW'(d_ff[2]) * PW'(u_ff[1]);
      cp_ff[2] <= PW'(d_ff[2]) * PW'(u_ff[0]);
      cp_ff[3] <= PW'(d_ff[0]) * PW'(u_ff[2]);
      cp_ff[4] <= PW'(d_ff[0]) * PW'(u_ff[1]);
      cp_ff[5] <= PW'(d_ff[1]) * PW'(u_ff[0]);
   end

   // Stage 3: sums.
   logic [63:0]          dsum_ff;
   logic signed [PW-1:0] dot_ff, yv_ff, zw_ff;
   logic signed [PW-1:0] c_ff [0:2];
   always_ff @(posedge clock) begin
      dsum_ff <= 64'(dd_ff[0]) + 64'(dd_ff[1]) + 64'(dd_ff[2]);
      dot_ff  <= du_ff[0] + du_ff[1] + du_ff[2];
      yv_ff   <= dv_ff[0] + dv_ff[1] + dv_ff[2];
      zw_ff   <= dw_ff[0] + dw_ff[1] + dw_ff[2];
      c_ff[0] <= cp_ff[0] - cp_ff[1];
      c_ff[1] <= cp_ff[2] - cp_ff[3];
      c_ff[2] <= cp_ff[4] - cp_ff[5];
   end

   // Stage 4: common right shift until all four are below 2^30.
   logic [PW-1:0] mx;
   logic [5:0]    sh;
   always_comb begin
      logic [PW-1:0] a;
      mx = dot_ff[PW-1] ? PW'(-dot_ff) : PW'(dot_ff);
      for (int k = 0; k < 3; k++) begin
         a = c_ff[k][PW-1] ? PW'(-c_ff[k]) : PW'(c_ff[k]);
         if (a > mx) mx = a;
      end
      sh = '0;
      for (int i = 30; i < PW; i++)
         if (mx[i]) sh = 6'(i - 29);
   end

   logic [63:0]          dsum4_ff;
   logic signed [PW-1:0] dot4_ff, yv4_ff, zw4_ff;
   logic signed [31:0]   t4_ff [0:2];
   always_ff @(posedge clock) begin
      dsum4_ff <= dsum_ff;
      dot4_ff  <= dot_ff >>> sh;
      yv4_ff   <= yv_ff;
      zw4_ff   <= zw_ff;
      for (int k = 0; k < 3; k++) t4_ff[k] <= 32'(c_ff[k] >>> sh);
   end

   // Stage 5: squares of the shifted cross product.
   logic [63:0] sqp_ff [0:2];
   logic [63:0] dsum5_ff;
   logic signed [PW-1:0] dot5_ff, yv5_ff, zw5_ff;
   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) sqp_ff[k] <= 64'(64'(t4_ff[k]) * 64'(t4_ff[k]));
      dsum5_ff <= dsum4_ff;
      dot5_ff <= dot4_ff; yv5_ff <= yv4_ff; zw5_ff <= zw4_ff;
   end

   // Stage 6: sum of squares, then both square roots.
   logic [63:0] csum_ff, dsum6_ff;
   logic signed [PW-1:0] dot6_ff, yv6_ff, zw6_ff;
   always_ff @(posedge clock) begin
      csum_ff  <= sqp_ff[0] + sqp_ff[1] + sqp_ff[2];
      dsum6_ff <= dsum5_ff;
      dot6_ff <= dot5_ff; yv6_ff <= yv5_ff; zw6_ff <= zw5_ff;
   end

   logic [31:0] droot, croot;
   logic [63:0] drem, crem;
   cda_isqrt u_dist_sqrt (.clock(clock), .in_value(dsum6_ff), .out_root(droot),
                          .out_rem(drem));
   cda_isqrt u_mag_sqrt (.clock(clock), .in_value(csum_ff), .out_root(croot),
                         .out_rem(crem));

   // Delay dot, yv, zw alongside the roots (32 stages).
   logic signed [PW-1:0] dotq_ff [0:31], yvq_ff [0:31], zwq_ff [0:31];
   always_ff @(posedge clock) begin
      dotq_ff[0] <= dot6_ff; yvq_ff[0] <= yv6_ff; zwq_ff[0] <= zw6_ff;
      for (int i = 1; i < 32; i++) begin
         dotq_ff[i] <= dotq_ff[i-1]; yvq_ff[i] <= yvq_ff[i-1]; zwq_ff[i] <= zwq_ff[i-1];
      end
   end

   // Distance rounding: +1 when remainder exceeds root; then saturate.
   logic [32:0] dround;
   logic [19:0] dist_in;
   always_comb begin
      dround = 33'(droot) + ((drem > 64'(droot)) ? 33'd1 : 33'd0);
      dist_in = (dround > 33'(cda_pkg::DIST_MAX)) ? cda_pkg::DIST_MAX : dround[19:0];
   end

   logic [19:0] distq_ff [0:25];
   logic        azero_ff;
   logic        azq_ff [0:25];
   always_ff @(posedge clock) begin
      distq_ff[0] <= dist_in;
      for (int i = 1; i < 26; i++) distq_ff[i] <= distq_ff[i-1];
      azq_ff[0] <= (croot == '0) && (dotq_ff[31] == '0);
      for (int i = 1; i < 26; i++) azq_ff[i] <= azq_ff[i-1];
   end
   assign azero_ff = azq_ff[25];

   logic signed [cda_pkg::Z_WIDTH-1:0] za, zb;
   cda_cordic u_alpha (.clock(clock), .in_y(PW'(croot)), .in_x(dotq_ff[31]), .out_z(za));
   cda_cordic u_beta  (.clock(clock), .in_y(zwq_ff[31]), .in_x(yvq_ff[31]), .out_z(zb));

   // Final stage: unit conversion, folds, gating.
   ctl_type c_fin;
   logic signed [15:0] al, be;
   assign c_fin = ctl_ff[LATENCY-1];
   always_comb begin
      al = azero_ff ? 16'sd0 : cda_pkg::to_out_unit(za);
      if (al < 0) al = '0;
      if (c_fin.us && al > cda_pkg::ANGLE_90) al = cda_pkg::ANGLE_180 - al;
      be = cda_pkg::to_out_unit(zb);
      if (c_fin.vs == cda_pkg::SYM_TWO) begin
         if (be < 0) be = -be;
      end else if (c_fin.vs == cda_pkg::SYM_FOUR) begin
         if (be < 0) be = -be;
         if (be > cda_pkg::ANGLE_90) be = cda_pkg::ANGLE_180 - be;
      end
      if (!c_fin.hu) begin
         al = '0;
         be = '0;
      end else if (!c_fin.hv) begin
         be = '0;
      end
   end

   logic [19:0] dist_ff;
   logic [14:0] alpha_ff;
   logic signed [15:0] beta_ff;
   logic av_ff, bv_ff;
   always_ff @(posedge clock) begin
      dist_ff  <= distq_ff[25];
      alpha_ff <= al[14:0];
      beta_ff  <= be;
      av_ff    <= c_fin.hu;
      bv_ff    <= c_fin.hu & c_fin.hv;
   end

   assign rsp_valid            = ctl_ff[LATENCY].vld;
   assign rsp_contact_distance = dist_ff;
   assign rsp_alpha_angle      = alpha_ff;
   assign rsp_beta_angle       = beta_ff;
   assign rsp_alpha_valid      = av_ff;
   assign rsp_beta_valid       = bv_ff;

   logic unused_ok;
   assign unused_ok = ^crem;

endmodule
